### rtl/core/stw_pkg.sv
// ----------------------------------------------------------------------------
// Strided address walk package
// Widths, register indexes, controller states and the command and status
// structs shared by the address walk modules.
// ----------------------------------------------------------------------------
package stw_pkg;

    localparam int NUM_DIMS     = 3;
    localparam int RANK_DEFAULT = 3;
    localparam int DIM_W        = 2;
    localparam int SIZE_W       = 16;
    localparam int STRIDE_W     = 32;
    localparam int BASE_W       = 32;
    localparam int EBYTES_W     = 4;
    localparam int OFFSET_W     = 56;
    localparam int PROD_W       = SIZE_W + 1 + STRIDE_W;
    localparam int ACC_W        = 52;
    localparam int SCALED_W     = ACC_W + EBYTES_W + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_OUTER    = 3'd0,
        CFG_SIZE_MIDDLE   = 3'd1,
        CFG_SIZE_INNER    = 3'd2,
        CFG_STRIDE_OUTER  = 3'd3,
        CFG_STRIDE_MIDDLE = 3'd4,
        CFG_STRIDE_INNER  = 3'd5,
        CFG_BASE_ELEMS    = 3'd6,
        CFG_ELEMENT_BYTES = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic             restart;
        logic             mac;
        logic [DIM_W-1:0] dim;
        logic             commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

### rtl/core/stw_in_if.sv
// ----------------------------------------------------------------------------
// Step request channel
// Valid/ready channel that carries one step request with its restart bit.
// ----------------------------------------------------------------------------
interface stw_in_if;

    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);

endinterface

### rtl/core/stw_out_if.sv
// ----------------------------------------------------------------------------
// Element address channel
// Valid/ready channel that carries one element address with its indices.
// ----------------------------------------------------------------------------
interface stw_out_if;

    import stw_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] elem_offset;
    logic [SIZE_W-1:0]   index_outer;
    logic [SIZE_W-1:0]   index_middle;
    logic [SIZE_W-1:0]   index_inner;
    logic                last;
    logic                empty_res;

    modport source (
        output valid, output elem_offset, output index_outer, output index_middle,
        output index_inner, output last, output empty_res, input ready
    );
    modport sink (
        input valid, input elem_offset, input index_outer, input index_middle,
        input index_inner, input last, input empty_res, output ready
    );

endinterface

### rtl/core/strided_tensor_address_walk.sv
// ----------------------------------------------------------------------------
// Strided tensor address walk
// Emits one element byte address per step request over a strided
// three-dimensional view in row-major order.
// ----------------------------------------------------------------------------
// Each accepted request yields one item: (base + sum of index times stride)
// times element size, the three indices, a last flag and an empty flag. A
// request passes through the accept step, one step per dimension through
// a single 17x32 multiply-accumulate unit, and a step that scales by the
// element size into the output register, which waits while that register
// is full. A new request is taken only once the previous one is committed;
// the output register lets the next request start while it waits to be taken.
// Write configuration only while no request is in flight.
module strided_tensor_address_walk #(
    parameter int RANK = stw_pkg::RANK_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [stw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stw_pkg::CFG_DATA_W-1:0]  cfg_data,
    stw_in_if.sink                          in_ch,
    stw_out_if.source                       out_ch
);

    import stw_pkg::*;

    cmd_t    cmd;
    status_t status;

    stw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_restart (in_ch.restart),
        .in_ready   (in_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    stw_datapath #(
        .RANK (RANK)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .elem_offset  (out_ch.elem_offset),
        .index_outer  (out_ch.index_outer),
        .index_middle (out_ch.index_middle),
        .index_inner  (out_ch.index_inner),
        .last         (out_ch.last),
        .empty_res    (out_ch.empty_res)
    );

endmodule

### rtl/core/stw_ctrl.sv
// ----------------------------------------------------------------------------
// Address walk controller
// Sequences one step: accept, one multiply-accumulate per dimension, then
// commit of the scaled result into the output register.
// ----------------------------------------------------------------------------
module stw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_restart,
    output logic              in_ready,
    input  stw_pkg::status_t  status,
    output stw_pkg::cmd_t     cmd
);

    import stw_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [DIM_W-1:0]   dim_reg;
    logic [DIM_W-1:0]   dim_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dim_reg   <= dim_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        dim_next    = dim_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.dim     = dim_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start   = 1'b1;
                    cmd.restart = in_restart;
                    dim_next    = '0;
                    state_next  = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac = 1'b1;
                if (dim_reg == DIM_W'(NUM_DIMS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    dim_next = dim_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/stw_datapath.sv
// ----------------------------------------------------------------------------
// Address walk datapath
// Configuration registers, index counter, shared stride multiplier with
// accumulator, element size scaling and the output register.
// ----------------------------------------------------------------------------
module stw_datapath #(
    parameter int RANK = stw_pkg::RANK_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [stw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  stw_pkg::cmd_t                    cmd,
    output stw_pkg::status_t                 status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [stw_pkg::OFFSET_W-1:0]     elem_offset,
    output logic [stw_pkg::SIZE_W-1:0]       index_outer,
    output logic [stw_pkg::SIZE_W-1:0]       index_middle,
    output logic [stw_pkg::SIZE_W-1:0]       index_inner,
    output logic                             last,
    output logic                             empty_res
);

    import stw_pkg::*;

    logic [SIZE_W-1:0]          size_reg   [NUM_DIMS];
    logic [STRIDE_W-1:0]        stride_reg [NUM_DIMS];
    logic [BASE_W-1:0]          base_reg;
    logic [EBYTES_W-1:0]        ebytes_reg;
    logic [SIZE_W-1:0]          pos_reg    [NUM_DIMS];
    logic [SIZE_W-1:0]          pos_adv    [NUM_DIMS];
    logic [SIZE_W-1:0]          size_eff   [NUM_DIMS];
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SCALED_W-1:0] scaled;
    logic                       empty;
    logic                       at_last;
    logic                       carry;
    logic [SIZE_W:0]            nx;

    logic                       out_valid_reg;
    logic [OFFSET_W-1:0]        offset_reg;
    logic [SIZE_W-1:0]          idx_outer_reg;
    logic [SIZE_W-1:0]          idx_middle_reg;
    logic [SIZE_W-1:0]          idx_inner_reg;
    logic                       last_reg;
    logic                       empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                size_reg[d]   <= SIZE_W'(1);
                stride_reg[d] <= STRIDE_W'(1);
            end
            base_reg   <= '0;
            ebytes_reg <= EBYTES_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_SIZE_OUTER:    size_reg[0]   <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_MIDDLE:   size_reg[1]   <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_INNER:    size_reg[2]   <= cfg_data[SIZE_W-1:0];
                CFG_STRIDE_OUTER:  stride_reg[0] <= cfg_data[STRIDE_W-1:0];
                CFG_STRIDE_MIDDLE: stride_reg[1] <= cfg_data[STRIDE_W-1:0];
                CFG_STRIDE_INNER:  stride_reg[2] <= cfg_data[STRIDE_W-1:0];
                CFG_BASE_ELEMS:    base_reg      <= cfg_data[BASE_W-1:0];
                CFG_ELEMENT_BYTES: ebytes_reg    <= cfg_data[EBYTES_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Dimensions outside the rank count as extent one.
    always_comb
    begin
        empty   = 1'b0;
        at_last = 1'b1;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            size_eff[d] = (d + RANK >= NUM_DIMS) ? size_reg[d] : SIZE_W'(1);
            if (size_eff[d] == '0)
            begin
                empty = 1'b1;
            end
            if (pos_reg[d] != size_eff[d] - 1'b1)
            begin
                at_last = 1'b0;
            end
        end
    end

    // Advance row-major, innermost first; an index at or past its extent wraps.
    always_comb
    begin
        carry = 1'b1;
        nx    = '0;
        for (int d = NUM_DIMS - 1; d >= 0; d--)
        begin
            nx = {1'b0, pos_reg[d]} + 1'b1;
            if (!carry)
            begin
                pos_adv[d] = pos_reg[d];
            end
            else if (nx < {1'b0, size_eff[d]})
            begin
                pos_adv[d] = nx[SIZE_W-1:0];
                carry      = 1'b0;
            end
            else
            begin
                pos_adv[d] = '0;
            end
        end
    end

    assign prod   = $signed({1'b0, pos_reg[cmd.dim]}) * $signed(stride_reg[cmd.dim]);
    assign scaled = acc_reg * $signed({1'b0, ebytes_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                pos_reg[d] <= '0;
            end
        end
        else if (cmd.start && cmd.restart)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                pos_reg[d] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                pos_reg[d] <= empty ? '0 : pos_adv[d];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= ACC_W'(base_reg);
        end
        else if (cmd.mac)
        begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (empty)
            begin
                offset_reg     <= '0;
                idx_outer_reg  <= '0;
                idx_middle_reg <= '0;
                idx_inner_reg  <= '0;
                last_reg       <= 1'b0;
                empty_reg      <= 1'b1;
            end
            else
            begin
                offset_reg     <= scaled[OFFSET_W-1:0];
                idx_outer_reg  <= pos_reg[0];
                idx_middle_reg <= pos_reg[1];
                idx_inner_reg  <= pos_reg[2];
                last_reg       <= at_last;
                empty_reg      <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign elem_offset     = offset_reg;
    assign index_outer     = idx_outer_reg;
    assign index_middle    = idx_middle_reg;
    assign index_inner     = idx_inner_reg;
    assign last            = last_reg;
    assign empty_res       = empty_reg;

endmodule

### tb/strided_tensor_address_walk_tb.sv
// ----------------------------------------------------------------------------
// Strided tensor address walk testbench
// Drives step requests and register writes into the address walker. It
// predicts each element address, the three indices and the last and empty
// flags with its own copy of the walk position, and compares every item
// taken from the output channel against the oldest expected entry. A short
// directed table comes first; randomized register settings and steps follow,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module strided_tensor_address_walk_tb;

    import stw_pkg::*;

    localparam int RANDOM_STEPS  = 1200;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 100;

    typedef struct packed {
        logic [OFFSET_W-1:0] elem_offset;
        logic [SIZE_W-1:0]   index_outer;
        logic [SIZE_W-1:0]   index_middle;
        logic [SIZE_W-1:0]   index_inner;
        logic                last;
        logic                empty_res;
    } elem_addr_t;

    typedef struct packed {
        logic       fixed;
        elem_addr_t addr;
    } typed_addr_t;

    typedef struct {
        logic                  is_write;
        cfg_reg_t              reg_sel;
        logic [CFG_DATA_W-1:0] data;
        logic                  restart;
        logic                  fixed;
        elem_addr_t            addr;
    } walk_row_t;

    localparam elem_addr_t SINGLE_ELEM = '{56'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0};
    localparam elem_addr_t EMPTY_VIEW  = '{56'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1};
    localparam elem_addr_t NO_ADDR     = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stw_in_if  in_ch ();
    stw_out_if out_ch ();

    strided_tensor_address_walk u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // walk shadow: index 0 outer, 1 middle, 2 inner
    logic [SIZE_W-1:0]          size_q   [NUM_DIMS] = '{16'd1, 16'd1, 16'd1};
    logic signed [STRIDE_W-1:0] stride_q [NUM_DIMS] = '{32'sd1, 32'sd1, 32'sd1};
    logic [BASE_W-1:0]          base_q   = '0;
    logic [EBYTES_W-1:0]        ebytes_q = 4'd1;
    logic [SIZE_W-1:0]          walk_pos [NUM_DIMS] = '{16'd0, 16'd0, 16'd0};

    elem_addr_t  pending_addrs [$];
    typed_addr_t typed_addrs [$];
    walk_row_t   walk_rows [$];

    int   errors       = 0;
    int   steps_seen   = 0;
    int   lasts_seen   = 0;
    int   empties_seen = 0;
    int   reg_writes   = 0;
    int   quiet_cycles = 0;
    logic src_idle_on  = 1'b1;
    logic sink_stalls  = 1'b1;
    logic hold_off     = 1'b0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int NUM_REGS();
        return CFG_ELEMENT_BYTES + 1;
    endfunction

    function automatic elem_addr_t next_element_addr(input logic restart);
        elem_addr_t  res;
        longint      acc;
        logic        at_end;
        logic [16:0] nx;
        int          d;
        res = '0;
        if (restart)
            walk_pos = '{16'd0, 16'd0, 16'd0};
        if (size_q[0] == 0 || size_q[1] == 0 || size_q[2] == 0) begin
            walk_pos = '{16'd0, 16'd0, 16'd0};
            res.empty_res = 1'b1;
            return res;
        end
        acc    = longint'({32'd0, base_q});
        at_end = 1'b1;
        for (d = 0; d < NUM_DIMS; d++) begin
            acc += longint'({48'd0, walk_pos[d]}) * longint'(stride_q[d]);
            if (walk_pos[d] != size_q[d] - 16'd1)
                at_end = 1'b0;
        end
        acc *= longint'({60'd0, ebytes_q});
        res.elem_offset  = acc[OFFSET_W-1:0];
        res.index_outer  = walk_pos[0];
        res.index_middle = walk_pos[1];
        res.index_inner  = walk_pos[2];
        res.last         = at_end;
        // advance, wrapping any index at or past its extent with a carry outward
        for (d = NUM_DIMS - 1; d >= 0; d--) begin
            nx = {1'b0, walk_pos[d]} + 17'd1;
            if (nx < {1'b0, size_q[d]}) begin
                walk_pos[d] = nx[SIZE_W-1:0];
                break;
            end
            walk_pos[d] = '0;
        end
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input cfg_reg_t sel);
        int r;
        r = $urandom_range(0, 99);
        case (sel)
            CFG_SIZE_OUTER, CFG_SIZE_MIDDLE, CFG_SIZE_INNER: begin
                if (r < 4)
                    return {16'($urandom), 16'd0};
                else if (r < 80)
                    return {16'($urandom), 16'($urandom_range(1, 4))};
                else if (r < 92)
                    return 32'($urandom_range(5, 16));
                else if (r < 96)
                    return 32'h0000_FFFF;
                return $urandom;
            end
            CFG_STRIDE_OUTER, CFG_STRIDE_MIDDLE, CFG_STRIDE_INNER: begin
                if (r < 40)
                    return 32'($signed($urandom_range(0, 16)) - 8);
                else if (r < 55) begin
                    case ($urandom_range(0, 3))
                        0:       return 32'h7FFF_FFFF;
                        1:       return 32'h8000_0000;
                        2:       return 32'h0000_0000;
                        default: return 32'hFFFF_FFFF;
                    endcase
                end
                return $urandom;
            end
            CFG_BASE_ELEMS: begin
                if (r < 50)
                    return 32'($urandom_range(0, 1000));
                else if (r < 65)
                    return (r < 58) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                return $urandom;
            end
            default: begin
                if (r < 70)
                    return {28'($urandom), 4'(1 << $urandom_range(0, 3))};
                return $urandom;
            end
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        case (sel)
            CFG_SIZE_OUTER:    size_q[0] = data[SIZE_W-1:0];
            CFG_SIZE_MIDDLE:   size_q[1] = data[SIZE_W-1:0];
            CFG_SIZE_INNER:    size_q[2] = data[SIZE_W-1:0];
            CFG_STRIDE_OUTER:  stride_q[0] = data[STRIDE_W-1:0];
            CFG_STRIDE_MIDDLE: stride_q[1] = data[STRIDE_W-1:0];
            CFG_STRIDE_INNER:  stride_q[2] = data[STRIDE_W-1:0];
            CFG_BASE_ELEMS:    base_q = data[BASE_W-1:0];
            default:           ebytes_q = data[EBYTES_W-1:0];
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_addrs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_step(input logic restart, input logic fixed, input elem_addr_t addr);
        int          gap;
        typed_addr_t entry;
        entry = '{fixed, addr};
        typed_addrs.insert(typed_addrs.size(), entry);
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic add_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
        walk_row_t row;
        row = '{1'b1, sel, data, 1'b0, 1'b0, NO_ADDR};
        walk_rows.insert(walk_rows.size(), row);
    endtask

    task automatic add_step(input logic restart, input logic fixed, input elem_addr_t addr);
        walk_row_t row;
        row = '{1'b0, CFG_SIZE_OUTER, '0, restart, fixed, addr};
        walk_rows.insert(walk_rows.size(), row);
    endtask

    task automatic check_field(input string name, input logic [OFFSET_W-1:0] want,
                               input logic [OFFSET_W-1:0] got);
        if (want !== got) begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : walk_monitor
        elem_addr_t  want;
        elem_addr_t  pred;
        elem_addr_t  expect_addr;
        typed_addr_t typed;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                steps_seen++;
                if (out_ch.last)
                    lasts_seen++;
                if (out_ch.empty_res)
                    empties_seen++;
                if (pending_addrs.size() == 0) begin
                    $display("%0t: item on output with nothing expected", $time);
                    errors++;
                end else begin
                    want = pending_addrs.pop_front();
                    check_field("elem_offset", want.elem_offset, out_ch.elem_offset);
                    check_field("index_outer", OFFSET_W'(want.index_outer),
                                OFFSET_W'(out_ch.index_outer));
                    check_field("index_middle", OFFSET_W'(want.index_middle),
                                OFFSET_W'(out_ch.index_middle));
                    check_field("index_inner", OFFSET_W'(want.index_inner),
                                OFFSET_W'(out_ch.index_inner));
                    check_field("last", OFFSET_W'(want.last), OFFSET_W'(out_ch.last));
                    check_field("empty_res", OFFSET_W'(want.empty_res),
                                OFFSET_W'(out_ch.empty_res));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pred        = next_element_addr(in_ch.restart);
                typed       = typed_addrs.pop_front();
                expect_addr = typed.fixed ? typed.addr : pred;
                pending_addrs.insert(pending_addrs.size(), expect_addr);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d items outstanding",
                         $time, QUIET_LIMIT, pending_addrs.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : sink_side
        int n;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off) begin
                n = HOLD_CYCLES;
                hold_off = 1'b0;
            end else if (sink_stalls) begin
                n = pick_gap();
            end else begin
                n = 0;
            end
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin : stimulus
        logic writing;
        int   phase;
        int   rand_steps;
        int   n;
        int   k;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SIZE_OUTER;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.restart = 1'b0;
        writing       = 1'b0;
        phase         = 0;
        rand_steps    = 0;

        add_step(1'b0, 1'b1, SINGLE_ELEM);
        add_step(1'b1, 1'b1, SINGLE_ELEM);
        add_write(CFG_SIZE_INNER, 32'h0000_0000);
        add_step(1'b0, 1'b1, EMPTY_VIEW);
        add_step(1'b1, 1'b1, EMPTY_VIEW);
        add_write(CFG_SIZE_INNER, 32'hFFFF_FFFF);
        add_write(CFG_STRIDE_INNER, 32'h7FFF_FFFF);
        add_write(CFG_BASE_ELEMS, 32'hFFFF_FFFF);
        add_write(CFG_ELEMENT_BYTES, 32'h0000_0008);
        add_step(1'b1, 1'b1, '{56'h7_FFFF_FFF8, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0});
        add_step(1'b0, 1'b0, NO_ADDR);
        add_write(CFG_STRIDE_INNER, 32'h8000_0000);
        add_step(1'b0, 1'b0, NO_ADDR);
        // shrink the inner extent below the running index
        add_write(CFG_SIZE_OUTER, 32'hFFFF_0002);
        add_write(CFG_SIZE_MIDDLE, 32'h0000_0002);
        add_write(CFG_SIZE_INNER, 32'h0000_0002);
        add_write(CFG_STRIDE_OUTER, 32'd100);
        add_write(CFG_STRIDE_MIDDLE, 32'hFFFF_FFF9);
        add_write(CFG_STRIDE_INNER, 32'd3);
        add_write(CFG_BASE_ELEMS, 32'd10);
        add_write(CFG_ELEMENT_BYTES, 32'hFFFF_FFF3);
        add_step(1'b0, 1'b0, NO_ADDR);
        add_step(1'b1, 1'b1, '{56'd30, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0});
        repeat (8) add_step(1'b0, 1'b0, NO_ADDR);
        add_write(CFG_ELEMENT_BYTES, 32'h0000_0000);
        add_step(1'b0, 1'b0, NO_ADDR);
        add_write(CFG_SIZE_OUTER, 32'h0000_0000);
        add_step(1'b0, 1'b1, EMPTY_VIEW);
        add_write(CFG_SIZE_OUTER, 32'h0000_0001);
        add_step(1'b0, 1'b0, NO_ADDR);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (walk_rows[i]) begin
            if (walk_rows[i].is_write) begin
                if (!writing)
                    settle();
                writing = 1'b1;
                write_reg(walk_rows[i].reg_sel, walk_rows[i].data);
            end else begin
                if (writing)
                    cfg_we <= 1'b0;
                writing = 1'b0;
                send_step(walk_rows[i].restart, walk_rows[i].fixed, walk_rows[i].addr);
            end
        end

        while (rand_steps < RANDOM_STEPS) begin
            settle();
            for (k = 0; k < NUM_REGS(); k++)
                if (phase == 0 || $urandom_range(0, 1) == 1)
                    write_reg(cfg_reg_t'(k), pick_reg_value(cfg_reg_t'(k)));
            cfg_we <= 1'b0;
            if (phase == 3) begin
                // hold the output side so the block backs up into its input
                hold_off    = 1'b1;
                src_idle_on = 1'b0;
                n           = 32;
            end else begin
                src_idle_on = $urandom_range(0, 3) != 0;
                n           = $urandom_range(8, 60);
            end
            sink_stalls = $urandom_range(0, 3) != 0;
            repeat (n) send_step($urandom_range(0, 99) < 5, 1'b0, NO_ADDR);
            rand_steps += n;
            phase++;
        end

        settle();
        $display("Covered %0d steps over %0d register writes in %0d random phases.",
                 steps_seen, reg_writes, phase);
        $display("Saw %0d final elements and %0d empty-view reports; %0d mismatches.",
                 lasts_seen, empties_seen, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
